### design/rcrc_pkg.sv
package rcrc_pkg;

  localparam int unsigned RemoteSlots  = 16;
  localparam int unsigned HistoryDepth = 8;
  localparam int unsigned SlotW = $clog2(RemoteSlots);
  localparam int unsigned SavedW = $clog2(RemoteSlots + 1);
  localparam int unsigned HistW = $clog2(HistoryDepth);
  localparam int unsigned FillW = $clog2(HistoryDepth + 1);
  localparam int unsigned CntW = 20;
  localparam int unsigned FixW = 32;

  localparam logic [1:0] CfgMode     = 2'd0;
  localparam logic [1:0] CfgDebounce = 2'd1;
  localparam logic [1:0] CfgOpen     = 2'd2;
  localparam logic [1:0] CfgResync   = 2'd3;

  localparam logic [15:0] DebounceReset = 16'd500;
  localparam logic [18:0] OpenReset     = 19'h00020;
  localparam logic [18:0] ResyncReset   = 19'h08000;

  localparam logic [3:0] VDebounced     = 4'd0;
  localparam logic [3:0] VProgIgnored   = 4'd1;
  localparam logic [3:0] VNotArmed      = 4'd2;
  localparam logic [3:0] VReplay        = 4'd3;
  localparam logic [3:0] VOpened        = 4'd4;
  localparam logic [3:0] VFuture        = 4'd5;
  localparam logic [3:0] VResynced      = 4'd6;
  localparam logic [3:0] VPast          = 4'd7;
  localparam logic [3:0] VUnknown       = 4'd8;
  localparam logic [3:0] VProgrammed    = 4'd9;
  localparam logic [3:0] VLearned       = 4'd10;
  localparam logic [3:0] VNormalIgnored = 4'd11;
  localparam logic [3:0] VFull          = 4'd12;

  typedef struct packed {
    logic        action;
    logic [31:0] serial_fix;
    logic [19:0] key_count;
    logic [31:0] now_ticks;
  } key_t;

  typedef struct packed {
    logic [3:0] verdict;
    logic [3:0] remote_index;
    logic       opened;
  } verdict_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic             load;        // capture key, compute gap
    logic             hist_write;  // write key into history at fill position
    logic             tbl_clear;   // clear scan results
    logic             tbl_step;    // evaluate table slot tbl_idx
    logic [SlotW-1:0] tbl_idx;
    logic             hist_step;   // evaluate history entry hist_idx
    logic [HistW-1:0] hist_idx;
    logic             commit;      // apply table updates, advance history
    logic             arm;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic              debounced;
    logic              mode;
    logic              armed;
    logic              action;
    logic [SavedW-1:0] saved;
    logic [HistW-1:0]  hf;
  } sts_t;

endpackage

### design/rcrc_datapath.sv
module rcrc_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rcrc_pkg::key_t   key_i,
  input  logic             cfg_we_i,
  input  rcrc_pkg::cfg_t   cfg_i,
  input  rcrc_pkg::ctl_t   ctl_i,
  output rcrc_pkg::sts_t   sts_o,
  output logic [3:0]       verdict_o,
  output logic [3:0]       index_o,
  output logic             opened_o
);
  import rcrc_pkg::*;

  logic        mode_q;
  logic [15:0] deb_q;
  logic [18:0] open_q, resync_q;
  logic [31:0] last_q;
  logic        armed_q;
  logic [SavedW-1:0] saved_q;
  logic [FillW-1:0]  fill_q;
  logic        deb_hit_q;
  key_t        key_q;

  logic [FixW-1:0] rt_fix_q [RemoteSlots];
  logic [CntW-1:0] rt_cnt_q [RemoteSlots];
  logic [FixW-1:0] kh_fix_q [HistoryDepth];
  logic [CntW-1:0] kh_cnt_q [HistoryDepth];

  // scan results
  logic             known_q, future_q, op_q, found_q, hdone_q;
  logic [3:0]       verd_q;
  logic [SlotW-1:0] slot_q;

  logic [31:0]     gap;
  logic [CntW-1:0] d, hnext;
  logic [HistW-1:0] hf;
  logic            hit_fix;

  assign gap = key_i.now_ticks - last_q;
  assign hf = (fill_q >= FillW'(HistoryDepth - 1)) ? HistW'(HistoryDepth - 1)
                                                   : fill_q[HistW-1:0];
  assign d = key_q.key_count - rt_cnt_q[ctl_i.tbl_idx];
  assign hnext = kh_cnt_q[ctl_i.hist_idx] + 1'b1;
  assign hit_fix = kh_fix_q[ctl_i.hist_idx] == key_q.serial_fix;

  assign sts_o.debounced = deb_hit_q;
  assign sts_o.mode = mode_q;
  assign sts_o.armed = armed_q;
  assign sts_o.action = key_q.action;
  assign sts_o.saved = saved_q;
  assign sts_o.hf = hf;

  always_comb begin
    if (!known_q) begin
      verdict_o = found_q ? VProgrammed : VUnknown;
      index_o = found_q ? 4'(saved_q) : 4'd0;
      opened_o = found_q;
    end else if (future_q && found_q) begin
      verdict_o = VResynced;
      index_o = 4'(slot_q);
      opened_o = 1'b1;
    end else begin
      verdict_o = verd_q;
      index_o = (verd_q == VOpened || verd_q == VFuture) ? 4'(slot_q) : 4'd0;
      opened_o = op_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      deb_q <= DebounceReset;
      open_q <= OpenReset;
      resync_q <= ResyncReset;
      last_q <= '0;
      armed_q <= 1'b0;
      saved_q <= '0;
      fill_q <= '0;
      deb_hit_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_i.index)
          CfgMode:     mode_q <= cfg_i.data[0];
          CfgDebounce: deb_q <= cfg_i.data[15:0];
          CfgOpen:     open_q <= cfg_i.data[18:0];
          CfgResync:   resync_q <= cfg_i.data[18:0];
          default: ;
        endcase
      end
      if (ctl_i.load) begin
        last_q <= key_i.now_ticks;
        deb_hit_q <= gap < 32'(deb_q);
      end
      if (ctl_i.arm) armed_q <= 1'b1;
      if (ctl_i.commit) begin
        if (!known_q && found_q) saved_q <= saved_q + 1'b1;
        if (fill_q < FillW'(HistoryDepth - 1)) fill_q <= fill_q + 1'b1;
        else fill_q <= FillW'(HistoryDepth - 1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) key_q <= key_i;
    if (ctl_i.hist_write) begin
      kh_fix_q[hf] <= key_q.serial_fix;
      kh_cnt_q[hf] <= key_q.key_count;
    end
    if (ctl_i.tbl_clear) begin
      known_q <= 1'b0; future_q <= 1'b0; op_q <= 1'b0;
      found_q <= 1'b0; hdone_q <= 1'b0;
      verd_q <= VUnknown; slot_q <= '0;
    end
    if (ctl_i.tbl_step && rt_fix_q[ctl_i.tbl_idx] == key_q.serial_fix) begin
      known_q <= 1'b1;
      if (d == '0) begin
        verd_q <= VReplay; slot_q <= '0; op_q <= 1'b0; future_q <= 1'b0;
      end else if (d <= CntW'(open_q)) begin
        rt_cnt_q[ctl_i.tbl_idx] <= key_q.key_count;
        verd_q <= VOpened; slot_q <= ctl_i.tbl_idx; op_q <= 1'b1; future_q <= 1'b0;
      end else if (d <= CntW'(resync_q)) begin
        verd_q <= VFuture; slot_q <= ctl_i.tbl_idx; op_q <= 1'b0; future_q <= 1'b1;
      end else begin
        verd_q <= VPast; slot_q <= '0; op_q <= 1'b0; future_q <= 1'b0;
      end
    end
    // history walk, newest first; learning stops at first serial match
    if (ctl_i.hist_step && !hdone_q && hit_fix) begin
      if (known_q) begin
        if (future_q && hnext == key_q.key_count) begin
          found_q <= 1'b1; hdone_q <= 1'b1;
        end
      end else if (saved_q < SavedW'(RemoteSlots)) begin
        hdone_q <= 1'b1;
        if (hnext == key_q.key_count) found_q <= 1'b1;
      end
    end
    if (ctl_i.commit) begin
      if (known_q && future_q && found_q) rt_cnt_q[slot_q] <= key_q.key_count;
      if (!known_q && found_q) begin
        rt_fix_q[saved_q[SlotW-1:0]] <= key_q.serial_fix;
        rt_cnt_q[saved_q[SlotW-1:0]] <= key_q.key_count;
      end
      if (fill_q >= FillW'(HistoryDepth - 1)) begin
        for (int i = 1; i < HistoryDepth; i++) begin
          kh_fix_q[i-1] <= kh_fix_q[i];
          kh_cnt_q[i-1] <= kh_cnt_q[i];
        end
        kh_fix_q[HistoryDepth-1] <= '0;
        kh_cnt_q[HistoryDepth-1] <= '0;
      end
    end
  end

endmodule

### design/rcrc_ctrl.sv
module rcrc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  rcrc_pkg::sts_t sts_i,
  output rcrc_pkg::ctl_t ctl_o,
  output logic           done_o,
  output logic [3:0]     fixed_verdict_o,
  output logic           use_fixed_o
);
  import rcrc_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StDecide, StTable, StHist, StCommit
  } state_e;

  state_e state_q;
  logic [SlotW-1:0] tidx_q;
  logic [HistW-1:0] hidx_q;

  always_comb begin
    ctl_o = '0;
    ctl_o.load = (state_q == StIdle) && start_i;
    ctl_o.tbl_idx = tidx_q;
    ctl_o.hist_idx = hidx_q - 1'b1;
    ctl_o.tbl_clear = state_q == StDecide;
    ctl_o.hist_write = (state_q == StDecide) && !sts_i.debounced && !sts_i.mode
                       && !sts_i.action && sts_i.armed;
    ctl_o.tbl_step = (state_q == StTable) && (SavedW'(tidx_q) < sts_i.saved);
    ctl_o.hist_step = (state_q == StHist) && (hidx_q != '0);
    ctl_o.commit = state_q == StCommit;
    ctl_o.arm = (state_q == StDecide) && !sts_i.debounced && sts_i.mode
                && !sts_i.armed && sts_i.action;
  end

  assign busy_o = state_q != StIdle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      tidx_q <= '0;
      hidx_q <= '0;
      done_o <= 1'b0;
      use_fixed_o <= 1'b0;
      fixed_verdict_o <= VDebounced;
    end else begin
      unique case (state_q)
        StIdle: begin
          done_o <= 1'b0;
          if (start_i) state_q <= StDecide;
        end
        StDecide: begin
          priority if (sts_i.debounced) begin
            use_fixed_o <= 1'b1;
            fixed_verdict_o <= VDebounced; done_o <= 1'b1; state_q <= StIdle;
          end else if (sts_i.mode) begin
            use_fixed_o <= 1'b1;
            fixed_verdict_o <= sts_i.armed ? VFull
                             : (sts_i.action ? VLearned : VNormalIgnored);
            done_o <= 1'b1; state_q <= StIdle;
          end else if (sts_i.action) begin
            use_fixed_o <= 1'b1;
            fixed_verdict_o <= VProgIgnored; done_o <= 1'b1; state_q <= StIdle;
          end else if (!sts_i.armed) begin
            use_fixed_o <= 1'b1;
            fixed_verdict_o <= VNotArmed; done_o <= 1'b1; state_q <= StIdle;
          end else begin
            use_fixed_o <= 1'b0; done_o <= 1'b0; tidx_q <= '0; state_q <= StTable;
          end
        end
        StTable: begin
          done_o <= 1'b0;
          if (tidx_q == SlotW'(RemoteSlots - 1)) begin
            hidx_q <= sts_i.hf; state_q <= StHist;
          end else tidx_q <= tidx_q + 1'b1;
        end
        StHist: begin
          done_o <= 1'b0;
          if (hidx_q == '0) state_q <= StCommit;
          else hidx_q <= hidx_q - 1'b1;
        end
        StCommit: begin
          done_o <= 1'b1; state_q <= StIdle;
        end
        default: begin
          done_o <= 1'b0; state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

### design/rolling_code_receiver_check.sv
// Rolling-code receiver check. Pulse start with a key on key_i while busy
// is low; the verdict appears on result_o for exactly one cycle with
// result_valid_o high and cannot be stalled, so the receiver must take it.
// Keys that end early (debounced, programming, disarmed) skip the scan; a
// full check runs the one-slot-per-cycle table scan over all RemoteSlots
// slots, followed by the newest-first history walk over the history fill
// (history fill at most 7 with 8 history entries).
// Configuration writes via cfg_valid_i/cfg_ready_o are accepted at any time
// but must only be issued while the block is idle.
module rolling_code_receiver_check (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  rcrc_pkg::key_t      key_i,
  output logic                result_valid_o,
  output rcrc_pkg::verdict_t  result_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  rcrc_pkg::cfg_t      cfg_i
);
  import rcrc_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic [3:0] dp_verdict, dp_index, fixed_verdict;
  logic dp_opened, use_fixed, done;

  assign cfg_ready_o = 1'b1;

  rcrc_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy),
    .sts_i(sts), .ctl_o(ctl), .done_o(done),
    .fixed_verdict_o(fixed_verdict), .use_fixed_o(use_fixed)
  );

  rcrc_datapath u_dp (
    .clk_i, .rst_ni, .key_i, .cfg_we_i(cfg_valid_i), .cfg_i,
    .ctl_i(ctl), .sts_o(sts),
    .verdict_o(dp_verdict), .index_o(dp_index), .opened_o(dp_opened)
  );

  // verdict is sampled when the commit step ends, before state updates land
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= done;
    end
  end

  // captures the datapath verdict at commit, or the fixed verdict of an early end
  always_ff @(posedge clk_i) begin
    if (ctl.commit) begin
      result_o <= '{verdict: dp_verdict, remote_index: dp_index, opened: dp_opened};
    end else if (done && use_fixed) begin
      result_o <= '{verdict: fixed_verdict, remote_index: 4'd0, opened: 1'b0};
    end
  end

endmodule
